FILE: src/lsipid_pkg.sv
// Package for the line-sensor incremental PID block.
// Holds the payload types, register indexes and the sensor pattern table.
// No dependencies.
package lsipid_pkg;

    localparam int PATTERN_W = 9;
    localparam int GAIN_W    = 16;
    localparam int ERR_W     = 6;
    localparam int DELTA_W   = 24;
    localparam int CFG_IDX_W = 2;

    typedef logic        [PATTERN_W-1:0] pattern_t;
    typedef logic        [GAIN_W-1:0]    gain_t;
    typedef logic signed [ERR_W-1:0]     err_t;
    typedef logic signed [DELTA_W-1:0]   delta_t;
    typedef logic        [CFG_IDX_W-1:0] cfg_index_t;

    localparam cfg_index_t REG_GAIN_PROP  = 2'd0;
    localparam cfg_index_t REG_GAIN_INTEG = 2'd1;
    localparam cfg_index_t REG_GAIN_DERIV = 2'd2;

    typedef struct packed {
        logic hit;
        err_t err;
    } map_t;

    // Exact-match table from sensor pattern to track error.
    function automatic map_t map_pattern(input pattern_t pat);
        map_t m;
        m.hit = 1'b1;
        case (pat)
            9'b100000000: m.err = -6'sd19;
            9'b110000000: m.err = -6'sd17;
            9'b010000000: m.err = -6'sd16;
            9'b011000000: m.err = -6'sd15;
            9'b001000000: m.err = -6'sd12;
            9'b001100000: m.err = -6'sd11;
            9'b000100000: m.err = -6'sd9;
            9'b000110000: m.err = -6'sd5;
            9'b000010000: m.err = -6'sd3;
            9'b000001000: m.err = 6'sd3;
            9'b000001100: m.err = 6'sd5;
            9'b000000100: m.err = 6'sd7;
            9'b000000110: m.err = 6'sd9;
            9'b000000010: m.err = 6'sd11;
            9'b000000011: m.err = 6'sd12;
            9'b000000001: m.err = 6'sd16;
            default:
            begin
                m.hit = 1'b0;
                m.err = '0;
            end
        endcase
        return m;
    endfunction

endpackage

FILE: src/line_sensor_incremental_pid.sv
// Top level of the line-sensor incremental PID block.
// Maps a sensor pattern to a track error and computes the incremental PID term.
// Depends on lsipid_pkg.
//
//  channel  | direction | handshake           | payload
//  ---------+-----------+---------------------+------------------------------
//  in       | request   | in_valid / in_stall | sensor_pattern
//  out      | result    | out_valid/out_stall | drive_delta, track_error
//  cfg      | write     | cfg_write           | cfg_index, cfg_data
//
// Each request is held in the input register and then moves to the result register,
// where its result is shown until it is taken.
// A new request is accepted every cycle while the output side is not stalled.
// Reset clears the gains, the error history and both valid flags.
// While out_stall holds a result, one more request can be taken into the
// input register before in_stall rises.
module line_sensor_incremental_pid (
    input  logic                    clk,
    input  logic                    rst_n,
    input  logic                    cfg_write,
    input  lsipid_pkg::cfg_index_t  cfg_index,
    input  lsipid_pkg::gain_t       cfg_data,
    input  logic                    in_valid,
    output logic                    in_stall,
    input  lsipid_pkg::pattern_t    sensor_pattern,
    output logic                    out_valid,
    input  logic                    out_stall,
    output lsipid_pkg::delta_t      drive_delta,
    output lsipid_pkg::err_t        track_error
);
    import lsipid_pkg::*;

    gain_t    gain_prop_reg;
    gain_t    gain_integ_reg;
    gain_t    gain_deriv_reg;

    logic     in_valid_reg;
    logic     in_valid_next;
    pattern_t pattern_reg;

    err_t     err_now_reg;
    err_t     err_last_reg;
    err_t     err_before_last_reg;
    err_t     err_next;

    logic     out_valid_reg;
    logic     out_valid_next;
    delta_t   delta_reg;
    delta_t   delta_next;

    logic     in_accept;
    logic     result_load;
    map_t     mapped;

    logic signed [7:0]  diff_p;
    logic signed [7:0]  diff_d;
    logic signed [7:0]  err_ext;
    logic signed [24:0] p_term;
    logic signed [24:0] i_term;
    logic signed [24:0] d_term;
    logic signed [25:0] total;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            gain_prop_reg  <= '0;
            gain_integ_reg <= '0;
            gain_deriv_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                REG_GAIN_PROP:  gain_prop_reg  <= cfg_data;
                REG_GAIN_INTEG: gain_integ_reg <= cfg_data;
                REG_GAIN_DERIV: gain_deriv_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign result_load = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall    = in_valid_reg && !result_load;
    assign in_accept   = in_valid && !in_stall;

    always_comb
    begin
        in_valid_next = in_valid_reg;
        if (in_accept)
        begin
            in_valid_next = 1'b1;
        end
        else if (result_load)
        begin
            in_valid_next = 1'b0;
        end
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (result_load)
        begin
            out_valid_next = 1'b1;
        end
        else if (!out_stall)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign mapped   = map_pattern(pattern_reg);
    assign err_next = mapped.hit ? mapped.err : err_now_reg;

    assign err_ext = {{2{err_next[ERR_W-1]}}, err_next};
    assign diff_p  = err_ext - {{2{err_now_reg[ERR_W-1]}}, err_now_reg};
    assign diff_d  = err_ext
                   - {{1{err_now_reg[ERR_W-1]}}, err_now_reg, 1'b0}
                   + {{2{err_last_reg[ERR_W-1]}}, err_last_reg};

    assign p_term = $signed({1'b0, gain_prop_reg})  * diff_p;
    assign i_term = $signed({1'b0, gain_integ_reg}) * err_ext;
    assign d_term = $signed({1'b0, gain_deriv_reg}) * diff_d;
    assign total  = {p_term[24], p_term} + {i_term[24], i_term} + {d_term[24], d_term};

    assign delta_next = total[DELTA_W-1:0];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg        <= 1'b0;
            out_valid_reg       <= 1'b0;
            err_now_reg         <= '0;
            err_last_reg        <= '0;
            err_before_last_reg <= '0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
            if (result_load)
            begin
                err_before_last_reg <= err_last_reg;
                err_last_reg        <= err_now_reg;
                err_now_reg         <= err_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (in_accept)
        begin
            pattern_reg <= sensor_pattern;
        end
        if (result_load)
        begin
            delta_reg <= delta_next;
        end
    end

    assign out_valid   = out_valid_reg;
    assign drive_delta = delta_reg;
    assign track_error = err_now_reg;

    // The shown error always lies inside the table's range.
    assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (track_error >= -6'sd19 && track_error <= 6'sd16))
        else $error("track error outside the table range");

    // The history moves by exactly one place for each result.
    assert property (@(posedge clk) disable iff (!rst_n)
        result_load |=> (err_last_reg == $past(err_now_reg)
                         && err_before_last_reg == $past(err_last_reg)))
        else $error("error history did not shift in step");

    // A pattern outside the table keeps the previous error.
    assert property (@(posedge clk) disable iff (!rst_n)
        (result_load && !mapped.hit) |=> err_now_reg == $past(err_now_reg))
        else $error("unlisted pattern changed the error");

    // The error history changes only when a result is loaded.
    assert property (@(posedge clk) disable iff (!rst_n)
        !result_load |=> $stable(err_now_reg) && $stable(err_last_reg))
        else $error("error history changed without a result");

    // A request waits in the input register only while a result is held.
    assert property (@(posedge clk) disable iff (!rst_n)
        (in_valid_reg && !result_load) |-> (out_valid_reg && out_stall))
        else $error("input register stuck without a held result");

endmodule
